// File: rtl/aes_eh_pkg.sv
// shared types, s-box and round helpers for the aes-128 encrypt and hash block
`timescale 1ns / 1ps

package aes_eh_pkg;

    localparam int NumRounds = 10;
    localparam int CfgIdxW   = 1;

    localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 1'b1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_HASH    = 1'b1;

    typedef struct packed {
        logic        op;
        logic [63:0] block_low;
        logic [63:0] block_high;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
    } out_item_t;

    typedef struct packed {
        logic         valid;
        logic         op;
        logic [127:0] orig;
        logic [127:0] st;
        logic [127:0] rk;
    } cell_data_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the block sits in bits 8i+7:8i
    function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
        get_byte = v[8*i +: 8];
    endfunction

endpackage

// File: rtl/aes128_encrypt_and_hash_top.sv
// top level of the aes-128 encrypt and fixed-key hash block
`timescale 1ns / 1ps

// Pipelined AES-128 encryptor with a fixed-key hash mode. One transaction is
// accepted every clock (busy is held low), and its result appears on the result
// ports with done high once it has passed the register for the initial key
// whitening and then each of the ten round cells in the chain, each
// cell also deriving its own round key on the fly. The result cannot be
// stalled. Key writes take effect for transactions started after the write.
module aes128_encrypt_and_hash_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  aes_eh_pkg::in_item_t    in_item,
    output logic                    done,
    output aes_eh_pkg::out_item_t   out_item,
    input  logic                    cfg_we,
    input  logic [aes_eh_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [63:0]             cfg_data
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic        v0_reg;
    logic [127:0] blk;
    logic [127:0] key;
    logic [127:0] res;
    logic         op0_reg;
    logic [127:0] orig0_reg;
    logic [127:0] st0_reg;
    logic [127:0] rk0_reg;
    aes_eh_pkg::cell_data_t chain [aes_eh_pkg::NumRounds+1];

    assign busy = 1'b0;
    assign blk  = {in_item.block_high, in_item.block_low};
    assign key  = {key_high_reg, key_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            v0_reg       <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
            if (cfg_we)
            begin
                case (cfg_index)
                    aes_eh_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    aes_eh_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op0_reg   <= in_item.op;
            orig0_reg <= blk;
            st0_reg   <= blk ^ key;
            rk0_reg   <= key;
        end
    end

    always_comb
    begin
        chain[0].valid = v0_reg;
        chain[0].op    = op0_reg;
        chain[0].orig  = orig0_reg;
        chain[0].st    = st0_reg;
        chain[0].rk    = rk0_reg;
    end

    for (genvar g = 0; g < aes_eh_pkg::NumRounds; g++)
    begin : g_round
        aes_eh_round_cell #(
            .RCON_VAL (aes_eh_pkg::RCON[g]),
            .LAST     (g == aes_eh_pkg::NumRounds - 1)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (chain[g]),
            .dout (chain[g+1])
        );
    end

    assign res = chain[aes_eh_pkg::NumRounds].st
               ^ ((chain[aes_eh_pkg::NumRounds].op == aes_eh_pkg::OP_HASH)
                  ? chain[aes_eh_pkg::NumRounds].orig : 128'd0);

    assign done                 = chain[aes_eh_pkg::NumRounds].valid;
    assign out_item.result_low  = res[63:0];
    assign out_item.result_high = res[127:64];

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##11 done) else $error("done missing after start");
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 11)) else $error("done without start");
    a_never_busy: assert property (@(posedge clk) !busy)
        else $error("busy raised");

endmodule

// File: rtl/aes_eh_round_cell.sv
// one aes round cell: round transform on the data and next round key
`timescale 1ns / 1ps

module aes_eh_round_cell #(
    parameter logic [7:0] RCON_VAL = 8'h01,
    parameter bit         LAST     = 1'b0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  aes_eh_pkg::cell_data_t din,
    output aes_eh_pkg::cell_data_t dout
);

    logic         valid_reg;
    logic         payload_en;
    logic [127:0] sub;
    logic [127:0] mixed;
    logic [127:0] rk_new;
    logic [31:0]  tw;
    logic         op_reg;
    logic [127:0] orig_reg;
    logic [127:0] st_reg;
    logic [127:0] rk_reg;

    // sub bytes with shift rows
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sub[8*(c*4+r) +: 8] =
                    aes_eh_pkg::SBOX[aes_eh_pkg::get_byte(din.st, ((c + r) % 4) * 4 + r)];
            end
        end
    end

    always_comb
    begin
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++)
        begin
            a0  = sub[8*(c*4)   +: 8];
            a1  = sub[8*(c*4+1) +: 8];
            a2  = sub[8*(c*4+2) +: 8];
            a3  = sub[8*(c*4+3) +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            mixed[8*(c*4)   +: 8] = a0 ^ all ^ aes_eh_pkg::xtime(a0 ^ a1);
            mixed[8*(c*4+1) +: 8] = a1 ^ all ^ aes_eh_pkg::xtime(a1 ^ a2);
            mixed[8*(c*4+2) +: 8] = a2 ^ all ^ aes_eh_pkg::xtime(a2 ^ a3);
            mixed[8*(c*4+3) +: 8] = a3 ^ all ^ aes_eh_pkg::xtime(a3 ^ a0);
        end
    end

    // key schedule step
    always_comb
    begin
        tw[7:0]   = aes_eh_pkg::SBOX[din.rk[111:104]] ^ RCON_VAL;
        tw[15:8]  = aes_eh_pkg::SBOX[din.rk[119:112]];
        tw[23:16] = aes_eh_pkg::SBOX[din.rk[127:120]];
        tw[31:24] = aes_eh_pkg::SBOX[din.rk[103:96]];
        rk_new[31:0]   = din.rk[31:0]   ^ tw;
        rk_new[63:32]  = din.rk[63:32]  ^ rk_new[31:0];
        rk_new[95:64]  = din.rk[95:64]  ^ rk_new[63:32];
        rk_new[127:96] = din.rk[127:96] ^ rk_new[95:64];
    end

    assign payload_en = din.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (payload_en)
        begin
            op_reg   <= din.op;
            orig_reg <= din.orig;
            st_reg   <= (LAST ? sub : mixed) ^ rk_new;
            rk_reg   <= rk_new;
        end
    end

    always_comb
    begin
        dout.valid = valid_reg;
        dout.op    = op_reg;
        dout.orig  = orig_reg;
        dout.st    = st_reg;
        dout.rk    = rk_reg;
    end

endmodule

// File: sim/tb_aes128_encrypt_and_hash_top.sv
// testbench for the aes-128 encrypt and fixed-key hash block
`timescale 1ns / 1ps

module tb_aes128_encrypt_and_hash_top;

    localparam int Latency = 11;
    localparam int CycleLimit = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    aes_eh_pkg::in_item_t in_item = '0;
    logic done;
    aes_eh_pkg::out_item_t out_item;
    logic cfg_we = 1'b0;
    logic [aes_eh_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    logic [63:0] key_lo_model = '0;
    logic [63:0] key_hi_model = '0;
    aes_eh_pkg::out_item_t expected_blocks[$];
    int errors = 0;
    int cycles = 0;
    int gap_pct = 0;

    aes128_encrypt_and_hash_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .done(done), .out_item(out_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    localparam logic [7:0] SubTable [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic aes_eh_pkg::out_item_t aes_hash_expected(input aes_eh_pkg::in_item_t it);
        logic [7:0] sched [176];
        logic [7:0] blk [16];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] w [4];
        logic [7:0] rc;
        logic [7:0] sum;
        logic [7:0] sv;
        aes_eh_pkg::out_item_t res;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
        begin
            sched[i] = key_lo_model[8*i +: 8];
            sched[i+8] = key_hi_model[8*i +: 8];
            blk[i] = it.block_low[8*i +: 8];
            blk[i+8] = it.block_high[8*i +: 8];
        end
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                w[j] = sched[i-4+j];
            if (i % 16 == 0)
            begin
                sv = w[0];
                w[0] = SubTable[w[1]] ^ rc;
                w[1] = SubTable[w[2]];
                w[2] = SubTable[w[3]];
                w[3] = SubTable[sv];
                rc = dbl(rc);
            end
            for (int j = 0; j < 4; j++)
                sched[i+j] = sched[i-16+j] ^ w[j];
        end
        for (int i = 0; i < 16; i++)
            s[i] = blk[i] ^ sched[i];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 4; k++)
                    t[c*4+k] = SubTable[s[((c+k)%4)*4+k]];
            if (r < 10)
                for (int c = 0; c < 4; c++)
                begin
                    w[0] = t[c*4]; w[1] = t[c*4+1]; w[2] = t[c*4+2]; w[3] = t[c*4+3];
                    sum = w[0] ^ w[1] ^ w[2] ^ w[3];
                    for (int k = 0; k < 4; k++)
                        t[c*4+k] = w[k] ^ sum ^ dbl(w[k] ^ w[(k+1)%4]);
                end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ sched[16*r+i];
        end
        if (it.op == aes_eh_pkg::OP_HASH)
            for (int i = 0; i < 16; i++)
                s[i] = s[i] ^ blk[i];
        for (int i = 0; i < 8; i++)
        begin
            res.result_low[8*i +: 8] = s[i];
            res.result_high[8*i +: 8] = s[i+8];
        end
        return res;
    endfunction

    task automatic send_block(input logic op, input logic [63:0] lo, input logic [63:0] hi);
        aes_eh_pkg::in_item_t it;
        it.op = op;
        it.block_low = lo;
        it.block_high = hi;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_blocks.push_back(aes_hash_expected(it));
        @(negedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (expected_blocks.size() != 0)
            @(negedge clk);
        repeat (Latency + 4) @(negedge clk);
    endtask

    task automatic write_key(input logic [aes_eh_pkg::CfgIdxW-1:0] idx,
                             input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == aes_eh_pkg::REG_KEY_LOW)
            key_lo_model = val;
        else
            key_hi_model = val;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_reset_key();
        send_block(aes_eh_pkg::OP_ENCRYPT, '0, '0);
        send_block(aes_eh_pkg::OP_HASH, '0, '0);
        send_block(aes_eh_pkg::OP_ENCRYPT, '1, '1);
        send_block(aes_eh_pkg::OP_HASH, '1, '1);
        settle();
    endtask

    task automatic test_known_vector();
        write_key(aes_eh_pkg::REG_KEY_LOW, 64'h0706050403020100);
        write_key(aes_eh_pkg::REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
        send_block(aes_eh_pkg::OP_ENCRYPT, 64'h7766554433221100, 64'hffeeddccbbaa9988);
        send_block(aes_eh_pkg::OP_HASH, 64'h7766554433221100, 64'hffeeddccbbaa9988);
        for (int b = 0; b < 64; b += 8)
        begin
            send_block(aes_eh_pkg::OP_ENCRYPT, 64'h1 << b, 64'h1 << (63 - b));
            send_block(aes_eh_pkg::OP_HASH, 64'h8000000000000000 >> b, 64'h1 << b);
        end
        settle();
    endtask

    task automatic test_key_extremes();
        write_key(aes_eh_pkg::REG_KEY_LOW, '1);
        write_key(aes_eh_pkg::REG_KEY_HIGH, '1);
        send_block(aes_eh_pkg::OP_ENCRYPT, '0, '1);
        send_block(aes_eh_pkg::OP_HASH, '1, '0);
        settle();
        write_key(aes_eh_pkg::REG_KEY_HIGH, '0);
        send_block(aes_eh_pkg::OP_HASH, rand64(), rand64());
        settle();
    endtask

    task automatic test_random(input int sender_gap, input int count);
        gap_pct = sender_gap;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                settle();
                write_key(aes_eh_pkg::REG_KEY_LOW, rand64());
                write_key(aes_eh_pkg::REG_KEY_HIGH, rand64());
            end
            send_block(1'($urandom_range(1)), rand64(), rand64());
        end
        settle();
        gap_pct = 0;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_item);
                errors = errors + 1;
            end
            else
            begin
                aes_eh_pkg::out_item_t exp_r;
                exp_r = expected_blocks.pop_front();
                if (out_item.result_low !== exp_r.result_low)
                begin
                    $display("%0t: result_low expected %h actual %h", $time,
                             exp_r.result_low, out_item.result_low);
                    errors = errors + 1;
                end
                if (out_item.result_high !== exp_r.result_high)
                begin
                    $display("%0t: result_high expected %h actual %h", $time,
                             exp_r.result_high, out_item.result_high);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CycleLimit)
        begin
            $display("aes128_encrypt_and_hash_top test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_key();
        test_known_vector();
        test_key_extremes();
        test_random(8, 420);
        test_random(46, 420);
        test_random(0, 420);
        settle();
        if (errors == 0 && expected_blocks.size() == 0)
            $display("aes128_encrypt_and_hash_top test passed");
        else
            $display("aes128_encrypt_and_hash_top test failed");
        $finish;
    end

endmodule
